[hw/rtl/hpg_pkg.sv]
package hpg_pkg;

  // microprogram addresses
  typedef enum logic [2:0] {
    S_FETCH    = 3'd0,
    S_DISPATCH = 3'd1,
    S_LOAD     = 3'd2,
    S_SCAN     = 3'd3,
    S_SWAP_RD  = 3'd4,
    S_SWAP_WR  = 3'd5,
    S_EXHAUST  = 3'd6,
    S_EMIT     = 3'd7
  } step_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LATCH,
    OP_LOAD,
    OP_SCAN,
    OP_SWAP_RD,
    OP_SWAP_WR,
    OP_EXHAUST,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_IN_VALID,
    C_CMD_NEXT,
    C_SCAN_END,
    C_COUNT_BELOW,
    C_OUT_FREE
  } cond_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_NEXT  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic  accept;
    op_t   op;
    cond_t cond_a;
    step_t tgt_a;
    cond_t cond_b;
    step_t tgt_b;
    step_t nxt;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic cmd_next;
    logic scan_end;
    logic count_below;
    logic out_free;
  } status_t;

  localparam int PACKED_ENTRIES = 8;
  localparam int PACK_BITS      = 3;

  function automatic ctrl_word_t ucode_rom(input step_t s);
    ctrl_word_t w;
    w = '{accept: 1'b0, op: OP_NONE, cond_a: C_NEVER, tgt_a: S_FETCH,
          cond_b: C_NEVER, tgt_b: S_FETCH, nxt: S_FETCH};
    unique case (s)
      S_FETCH: begin
        w.accept = 1'b1;
        w.op     = OP_LATCH;
        w.cond_a = C_IN_VALID;
        w.tgt_a  = S_DISPATCH;
        w.nxt    = S_FETCH;
      end
      S_DISPATCH: begin
        w.cond_a = C_CMD_NEXT;
        w.tgt_a  = S_SCAN;
        w.nxt    = S_LOAD;
      end
      S_LOAD: begin
        w.op  = OP_LOAD;
        w.nxt = S_EMIT;
      end
      S_SCAN: begin
        w.op     = OP_SCAN;
        w.cond_a = C_SCAN_END;
        w.tgt_a  = S_EXHAUST;
        w.cond_b = C_COUNT_BELOW;
        w.tgt_b  = S_SWAP_RD;
        w.nxt    = S_SCAN;
      end
      S_SWAP_RD: begin
        w.op  = OP_SWAP_RD;
        w.nxt = S_SWAP_WR;
      end
      S_SWAP_WR: begin
        w.op  = OP_SWAP_WR;
        w.nxt = S_EMIT;
      end
      S_EXHAUST: begin
        w.op  = OP_EXHAUST;
        w.nxt = S_EMIT;
      end
      S_EMIT: begin
        w.op     = OP_EMIT;
        w.cond_a = C_OUT_FREE;
        w.tgt_a  = S_FETCH;
        w.nxt    = S_EMIT;
      end
      default: w.nxt = S_FETCH;
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/heap_permutation_generator.sv]
// Permutation generator after the iterative form of Heap's algorithm. A start beat
// (in_tuser = 0) takes a length in in_tdata[3:0], saturated to MAX_LEN, and returns the
// identity list; each next beat (in_tuser = 1) returns the list after one more swap, or
// flags exhaustion once every permutation has been produced. Control runs from a small
// microprogram ROM stepping a plain register datapath, one item at a time. A next scans
// the counters from the walk position upward, one position per cycle, until it finds a
// position k to swap or reaches the end of the list and flags exhaustion. k averages
// below 2 over a full enumeration. A result still stalled on out_tready holds the next
// one back in its final step. The next beat is accepted as soon as the result is
// registered, even while it waits on out_tready.
module heap_permutation_generator #(
  parameter int MAX_LEN = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // length[3:0], zero pad
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // perm_word[23:0], swap_first, swap_second, zero pad
  output logic [1:0]  out_tuser   // swapped, exhausted
);

  hpg_pkg::ctrl_word_t ctrl;
  hpg_pkg::status_t    status;

  hpg_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  hpg_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  assign in_tready = ctrl.accept;

endmodule

[hw/rtl/hpg_sequencer.sv]
module hpg_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  hpg_pkg::status_t    status,
  output hpg_pkg::ctrl_word_t ctrl
);

  hpg_pkg::step_t upc_r, upc_nxt;
  logic           hit_a, hit_b;

  function automatic logic cond_true(input hpg_pkg::cond_t c, input hpg_pkg::status_t st);
    logic r;
    r = 1'b0;
    unique case (c)
      hpg_pkg::C_NEVER:       r = 1'b0;
      hpg_pkg::C_IN_VALID:    r = st.in_valid;
      hpg_pkg::C_CMD_NEXT:    r = st.cmd_next;
      hpg_pkg::C_SCAN_END:    r = st.scan_end;
      hpg_pkg::C_COUNT_BELOW: r = st.count_below;
      hpg_pkg::C_OUT_FREE:    r = st.out_free;
      default:                r = 1'b0;
    endcase
    return r;
  endfunction

  assign ctrl  = hpg_pkg::ucode_rom(upc_r);
  assign hit_a = cond_true(ctrl.cond_a, status);
  assign hit_b = cond_true(ctrl.cond_b, status);

  always_comb begin
    priority if (hit_a) begin
      upc_nxt = ctrl.tgt_a;
    end else if (hit_b) begin
      upc_nxt = ctrl.tgt_b;
    end else begin
      upc_nxt = ctrl.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= hpg_pkg::S_FETCH;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

[hw/rtl/hpg_datapath.sv]
module hpg_datapath #(
  parameter int MAX_LEN = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hpg_pkg::ctrl_word_t ctrl,
  input  logic                in_tvalid,
  input  logic [7:0]          in_tdata,
  input  logic                in_tuser,
  input  logic                out_tready,
  output hpg_pkg::status_t    status,
  output logic                out_tvalid,
  output logic [31:0]         out_tdata,
  output logic [1:0]          out_tuser
);

  localparam int EW = $clog2(MAX_LEN);
  localparam int KW = $clog2(MAX_LEN + 1);
  localparam int LW = (KW > 4) ? KW : 4;

  logic [EW-1:0] entry_r [MAX_LEN];
  logic [EW-1:0] entry_nxt [MAX_LEN];
  logic [EW-1:0] cnt_r [MAX_LEN];
  logic [EW-1:0] cnt_nxt [MAX_LEN];
  logic [KW-1:0] walk_r, walk_nxt;
  logic [KW-1:0] len_r, len_nxt;
  logic          cmd_r, cmd_nxt;
  logic [3:0]    req_len_r, req_len_nxt;
  logic [EW-1:0] tmp_r, tmp_nxt;
  logic [2:0]    first_r, first_nxt;
  logic [2:0]    second_r, second_nxt;
  logic          swapped_r, swapped_nxt;
  logic          done_r, done_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_data_r, out_data_nxt;
  logic [1:0]    out_user_r, out_user_nxt;

  logic [EW-1:0] cur_k;
  logic [EW-1:0] cnt_k;
  logic [EW-1:0] sel_a;
  logic [EW+2:0] a_ext;
  logic [KW+2:0] k_ext;
  logic [LW-1:0] req_ext;
  logic [KW-1:0] len_sat;
  logic [23:0]   perm_w;
  logic          out_free;
  logic          count_below;
  logic          scan_end;

  assign cur_k       = walk_r[EW-1:0];
  assign cnt_k       = cnt_r[cur_k];
  assign sel_a       = walk_r[0] ? cnt_k : '0;
  assign a_ext       = {3'b000, sel_a};
  assign k_ext       = {3'b000, walk_r};
  assign req_ext     = LW'(req_len_r);
  assign len_sat     = (req_ext > LW'(MAX_LEN)) ? KW'(MAX_LEN) : KW'(req_ext);
  assign count_below = KW'(cnt_k) < walk_r;
  assign scan_end    = walk_r >= len_r;
  assign out_free    = !out_valid_r || out_tready;

  assign status.in_valid    = in_tvalid;
  assign status.cmd_next    = (cmd_r == hpg_pkg::CMD_NEXT);
  assign status.scan_end    = scan_end;
  assign status.count_below = count_below;
  assign status.out_free    = out_free;

  for (genvar i = 0; i < hpg_pkg::PACKED_ENTRIES; i++) begin : g_pack
    if (i < MAX_LEN) begin : g_live
      logic [EW+2:0] e_ext;
      assign e_ext = {3'b000, entry_r[i]};
      assign perm_w[i*hpg_pkg::PACK_BITS +: hpg_pkg::PACK_BITS] =
        (KW'(i) < len_r) ? e_ext[2:0] : 3'b000;
    end else begin : g_pad
      assign perm_w[i*hpg_pkg::PACK_BITS +: hpg_pkg::PACK_BITS] = 3'b000;
    end
  end

  always_comb begin
    entry_nxt     = entry_r;
    cnt_nxt       = cnt_r;
    walk_nxt      = walk_r;
    len_nxt       = len_r;
    cmd_nxt       = cmd_r;
    req_len_nxt   = req_len_r;
    tmp_nxt       = tmp_r;
    first_nxt     = first_r;
    second_nxt    = second_r;
    swapped_nxt   = swapped_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    unique case (ctrl.op)
      hpg_pkg::OP_NONE: begin
      end
      hpg_pkg::OP_LATCH: begin
        if (in_tvalid) begin
          cmd_nxt     = in_tuser;
          req_len_nxt = in_tdata[3:0];
        end
      end
      hpg_pkg::OP_LOAD: begin
        for (int i = 0; i < MAX_LEN; i++) begin
          entry_nxt[i] = EW'(i);
          cnt_nxt[i]   = '0;
        end
        walk_nxt    = '0;
        len_nxt     = len_sat;
        first_nxt   = 3'b000;
        second_nxt  = 3'b000;
        swapped_nxt = 1'b0;
        done_nxt    = 1'b0;
      end
      hpg_pkg::OP_SCAN: begin
        if (!scan_end && !count_below) begin
          cnt_nxt[cur_k] = '0;
          walk_nxt       = walk_r + KW'(1);
        end
      end
      hpg_pkg::OP_SWAP_RD: begin
        tmp_nxt = entry_r[cur_k];
      end
      hpg_pkg::OP_SWAP_WR: begin
        entry_nxt[cur_k] = entry_r[sel_a];
        entry_nxt[sel_a] = tmp_r;
        cnt_nxt[cur_k]   = cnt_k + EW'(1);
        walk_nxt         = '0;
        first_nxt        = a_ext[2:0];
        second_nxt       = k_ext[2:0];
        swapped_nxt      = 1'b1;
        done_nxt         = 1'b0;
      end
      hpg_pkg::OP_EXHAUST: begin
        first_nxt   = 3'b000;
        second_nxt  = 3'b000;
        swapped_nxt = 1'b0;
        done_nxt    = 1'b1;
      end
      hpg_pkg::OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, second_r, first_r, perm_w};
          out_user_nxt  = {done_r, swapped_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_LEN; i++) begin
        entry_r[i] <= EW'(i);
        cnt_r[i]   <= '0;
      end
      walk_r      <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      entry_r     <= entry_nxt;
      cnt_r       <= cnt_nxt;
      walk_r      <= walk_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    req_len_r  <= req_len_nxt;
    tmp_r      <= tmp_nxt;
    first_r    <= first_nxt;
    second_r   <= second_nxt;
    swapped_r  <= swapped_nxt;
    done_r     <= done_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

[hw/rtl/hpg_checker.sv]
module hpg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("swapped and exhausted together");

  a_no_swap_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[29:24] == 6'd0)
    else $error("swap positions set without a swap");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("not ready and empty after reset");

  // one beat in flight: no second acceptance right after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

endmodule

bind heap_permutation_generator hpg_checker u_hpg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[test/heap_permutation_generator_test.sv]
`timescale 1ns / 1ps

module heap_permutation_generator_test;

  localparam int LIST_MAX = 8;

  typedef struct packed {
    logic [23:0] perm_word;
    logic [2:0]  swap_first;
    logic [2:0]  swap_second;
    logic        swapped;
    logic        exhausted;
  } perm_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  // permutation state as the block should hold it
  logic [2:0] heap_order [LIST_MAX];
  logic [2:0] heap_count [LIST_MAX];
  logic [3:0] heap_walk;
  logic [3:0] heap_len;

  perm_beat_t pending_perms [$];
  int         bad_beats = 0;
  int         beats_sent = 0;
  int         send_idle_pct = 0;
  int         take_stall_pct = 0;

  heap_permutation_generator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  initial begin
    #4ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic perm_beat_t advance_heap_model(hpg_pkg::cmd_t cmd, logic [3:0] len);
    perm_beat_t r;
    int         k;
    logic [2:0] a;
    logic [2:0] t;
    r = '0;
    if (cmd == hpg_pkg::CMD_START) begin
      for (int i = 0; i < LIST_MAX; i++) begin
        heap_order[i] = 3'(i);
        heap_count[i] = '0;
      end
      heap_walk = '0;
      heap_len  = (len > LIST_MAX) ? 4'(LIST_MAX) : len;
    end else begin
      k = heap_walk;
      while (k < heap_len && !r.swapped) begin
        if (heap_count[k] < k) begin
          a = (k % 2 == 0) ? 3'd0 : heap_count[k];
          t = heap_order[a];
          heap_order[a] = heap_order[k];
          heap_order[k] = t;
          heap_count[k] = heap_count[k] + 3'd1;
          r.swap_first  = a;
          r.swap_second = 3'(k);
          r.swapped     = 1'b1;
        end else begin
          heap_count[k] = '0;
          k++;
        end
      end
      if (r.swapped) begin
        heap_walk = '0;
      end else begin
        heap_walk   = 4'(k);
        r.exhausted = 1'b1;
      end
    end
    for (int i = 0; i < heap_len && i < LIST_MAX; i++)
      r.perm_word[3*i +: 3] = heap_order[i];
    return r;
  endfunction

  task automatic set_idling(int send_pct, int stall_pct);
    send_idle_pct  = send_pct;
    take_stall_pct = stall_pct;
  endtask

  task automatic send_item(hpg_pkg::cmd_t cmd, logic [3:0] len);
    @(negedge clk);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      in_tuser  <= 1'($urandom_range(1, 0));
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'h0, len};
    do @(posedge clk); while (!in_tready);
    pending_perms.push_back(advance_heap_model(cmd, len));
    beats_sent++;
  endtask

  always @(negedge clk) out_tready <= ($urandom_range(99, 0) >= take_stall_pct);

  always @(posedge clk) begin
    perm_beat_t got;
    perm_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.perm_word   = out_tdata[23:0];
      got.swap_first  = out_tdata[26:24];
      got.swap_second = out_tdata[29:27];
      got.swapped     = out_tuser[0];
      got.exhausted   = out_tuser[1];
      if (pending_perms.size() == 0) begin
        bad_beats++;
        if (bad_beats <= 10)
          $display("unexpected result beat: perm %h first %0d second %0d swapped %b exh %b",
                   got.perm_word, got.swap_first, got.swap_second, got.swapped,
                   got.exhausted);
      end else begin
        want = pending_perms.pop_front();
        if (got.perm_word !== want.perm_word || got.swap_first !== want.swap_first ||
            got.swap_second !== want.swap_second || got.swapped !== want.swapped ||
            got.exhausted !== want.exhausted) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("mismatch: want perm %h first %0d second %0d swapped %b exh %b, %s",
                     want.perm_word, want.swap_first, want.swap_second, want.swapped,
                     want.exhausted,
                     $sformatf("got perm %h first %0d second %0d swapped %b exh %b",
                               got.perm_word, got.swap_first, got.swap_second,
                               got.swapped, got.exhausted));
        end
      end
    end
  end

  task automatic check_fresh_state;
    send_item(hpg_pkg::CMD_NEXT, 4'd5);
    send_item(hpg_pkg::CMD_NEXT, 4'd0);
  endtask

  task automatic check_short_lengths;
    send_item(hpg_pkg::CMD_START, 4'd0);
    send_item(hpg_pkg::CMD_NEXT, 4'd15);
    send_item(hpg_pkg::CMD_START, 4'd1);
    send_item(hpg_pkg::CMD_NEXT, 4'd0);
    send_item(hpg_pkg::CMD_START, 4'd15);
    send_item(hpg_pkg::CMD_NEXT, 4'd10);
    send_item(hpg_pkg::CMD_START, 4'd9);
    send_item(hpg_pkg::CMD_NEXT, 4'd0);
  endtask

  task automatic check_length_three_cycle;
    send_item(hpg_pkg::CMD_START, 4'd3);
    repeat (7) send_item(hpg_pkg::CMD_NEXT, 4'd3);
  endtask

  task automatic check_restart;
    send_item(hpg_pkg::CMD_START, 4'd4);
    repeat (3) send_item(hpg_pkg::CMD_NEXT, 4'd0);
    send_item(hpg_pkg::CMD_START, 4'd2);
    repeat (3) send_item(hpg_pkg::CMD_NEXT, 4'd0);
  endtask

  // full walk of a six entry list, through exhaustion and a little past it
  task automatic check_deep_walk;
    send_item(hpg_pkg::CMD_START, 4'd6);
    repeat (722) send_item(hpg_pkg::CMD_NEXT, 4'($urandom_range(15, 0)));
  endtask

  task automatic run_random_walks(int target);
    int phase_send [4] = '{0, 48, 0, 34};
    int phase_stall [4] = '{0, 0, 48, 34};
    int first_beat;
    int pick;
    int eff;
    int full;
    int steps;
    logic [3:0] len;
    for (int p = 0; p < 4; p++) begin
      set_idling(phase_send[p], phase_stall[p]);
      first_beat = beats_sent;
      while (beats_sent - first_beat < target / 4) begin
        if ($urandom_range(99, 0) < 85) begin
          pick = $urandom_range(99, 0);
          if (pick < 45)
            len = 4'($urandom_range(4, 2));
          else if (pick < 75)
            len = 4'($urandom_range(6, 5));
          else if (pick < 90)
            len = 4'($urandom_range(8, 7));
          else
            len = 4'($urandom_range(15, 0));
          send_item(hpg_pkg::CMD_START, len);
          eff  = (len > LIST_MAX) ? LIST_MAX : len;
          full = 1;
          for (int i = 2; i <= eff; i++) full *= i;
          // short lists mostly get a full walk plus up to two nexts past exhaustion, else 1 to full (or 60) nexts
          if (eff <= 4 && $urandom_range(99, 0) < 70)
            steps = full + $urandom_range(2, 0);
          else
            steps = $urandom_range((eff <= 4) ? full : 60, 1);
          repeat (steps) send_item(hpg_pkg::CMD_NEXT, 4'($urandom_range(15, 0)));
        end else begin
          send_item(hpg_pkg::cmd_t'($urandom_range(1, 0)), 4'($urandom_range(15, 0)));
        end
      end
    end
  endtask

  initial begin
    int guard;
    for (int i = 0; i < LIST_MAX; i++) begin
      heap_order[i] = 3'(i);
      heap_count[i] = '0;
    end
    heap_walk = '0;
    heap_len  = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    set_idling(0, 0);
    check_fresh_state();
    check_short_lengths();
    check_length_three_cycle();
    check_restart();
    set_idling(34, 34);
    check_deep_walk();
    run_random_walks(480);
    @(negedge clk);
    in_tvalid <= 1'b0;
    guard = 0;
    while (pending_perms.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (30) @(posedge clk);
    if (bad_beats == 0 && pending_perms.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
